// File: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the sensor frame parser
// no dependencies

package sfp_pkg;

  localparam logic [7:0]  SYNC_BYTE     = 8'h5A;
  localparam logic [7:0]  TYPE_LIGHT    = 8'h15;
  localparam logic [7:0]  TYPE_ENV      = 8'h45;
  localparam logic [7:0]  LEN_LIGHT     = 8'h04;
  localparam logic [7:0]  LEN_ENV       = 8'h0A;
  localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
  localparam logic [15:0] TICKS_MAX     = 16'hFFFF;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam int PAYLOAD_BYTES_DEF = 11;
  localparam int QUEUE_DEPTH_DEF   = 2;

  typedef struct packed {
    logic       timed_out;
    logic [7:0] rx_byte;
  } sfp_item_t;

  typedef struct packed {
    logic [15:0] altitude_hundredths;
    logic [15:0] humidity_hundredths;
    logic [31:0] pressure_hundredths;
    logic [15:0] temperature_hundredths;
    logic [31:0] lux_hundredths;
  } sfp_result_t;

endpackage

// File: rtl/sensor_frame_parser_core.sv
`timescale 1ns / 1ps
// Sensor frame parser. Takes one transaction per clock while s_axis_tready is
// high: a serial byte (tuser 0) or a millisecond tick (tuser 1). Ticks are
// absorbed by the idle timer in the front part; bytes pass through a two-entry
// queue into the frame state machine, which updates once per byte. For a
// good frame m_axis_tvalid, held in an output register, rises in the cycle after
// its checksum byte is popped; a stalled output fills the queue, then drops s_axis_tready.
// depends on sfp_pkg, sfp_front, sfp_queue, sfp_back

module sensor_frame_parser_core import sfp_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF,
  parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_wr_en,
  input  logic [15:0]  cfg_wr_data,   // idle_timeout_ticks
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,  // rx_byte
  input  logic         s_axis_tuser,  // cmd
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // lux_hundredths, temperature_hundredths, pressure_hundredths,
  // humidity_hundredths, altitude_hundredths
  output logic [111:0] m_axis_tdata,
  output logic         m_axis_tuser   // frame_kind
);

  logic        push;
  logic        push_ready;
  sfp_item_t   push_item;
  logic        q_valid;
  logic        q_pop;
  sfp_item_t   q_item;
  sfp_result_t result;

  sfp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (s_axis_tvalid),
    .in_ready    (s_axis_tready),
    .in_cmd      (s_axis_tuser),
    .in_byte     (s_axis_tdata),
    .push        (push),
    .push_item   (push_item),
    .push_ready  (push_ready)
  );

  sfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (push),
    .wr_item  (push_item),
    .wr_ready (push_ready),
    .rd_en    (q_pop),
    .rd_item  (q_item),
    .rd_valid (q_valid)
  );

  sfp_back #(
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (q_valid),
    .item       (q_item),
    .pop        (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_kind   (m_axis_tuser),
    .out_result (result)
  );

  assign m_axis_tdata = result;

endmodule

// File: rtl/sfp_front.sv
`timescale 1ns / 1ps
// front end: accepts bytes and ticks, keeps the idle timer and timeout register
// depends on sfp_pkg

module sfp_front import sfp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [7:0]  in_byte,
  output logic        push,
  output sfp_item_t   push_item,
  input  logic        push_ready
);

  logic [15:0] idle_timeout_ticks;
  logic [15:0] idle_ticks;
  logic        accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && push_ready;
  assign push     = accept && (in_cmd == CMD_BYTE);

  assign push_item.timed_out = idle_ticks > idle_timeout_ticks;
  assign push_item.rx_byte   = in_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_wr_en) begin
      idle_timeout_ticks <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_ticks <= '0;
    end else if (accept) begin
      if (in_cmd == CMD_TICK) begin
        if (idle_ticks != TICKS_MAX) begin
          idle_ticks <= idle_ticks + 16'd1;
        end
      end else begin
        idle_ticks <= '0;
      end
    end
  end

endmodule

// File: rtl/sfp_queue.sv
`timescale 1ns / 1ps
// small fifo between the front and back parts
// depends on sfp_pkg

module sfp_queue import sfp_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      wr_en,
  input  sfp_item_t wr_item,
  output logic      wr_ready,
  input  logic      rd_en,
  output sfp_item_t rd_item,
  output logic      rd_valid
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  sfp_item_t        mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != CNT_W'(DEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_en && wr_ready;
  assign do_rd    = rd_en && rd_valid;
  assign rd_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/sfp_back.sv
`timescale 1ns / 1ps
// back end: frame state machine, payload buffer, checksum and result register
// depends on sfp_pkg

module sfp_back import sfp_pkg::*; #(
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  sfp_item_t   item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output sfp_result_t out_result
);

  localparam int IDX_W = $clog2(PAYLOAD_BYTES);

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_TYPE = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_PAY  = 2'd3;

  logic [1:0] parse_phase, parse_phase_next, phase_eff;
  logic [3:0] byte_count, byte_count_next, cnt_eff, cnt_inc;
  logic [3:0] expected_count, expected_count_next;
  logic       frame_is_env, frame_is_env_next;
  logic [7:0] running_sum, sum_base;
  logic [7:0] payload_store [PAYLOAD_BYTES];
  logic [7:0] c;
  logic       store_we;
  logic       emit;
  sfp_result_t res;

  assign pop = item_valid && (!out_valid || out_ready);
  assign c   = item.rx_byte;

  assign phase_eff = item.timed_out ? PH_HUNT : parse_phase;
  assign cnt_eff   = item.timed_out ? 4'd0 : byte_count;
  assign cnt_inc   = cnt_eff + 4'd1;

  always_comb begin
    parse_phase_next    = phase_eff;
    byte_count_next     = cnt_eff;
    expected_count_next = expected_count;
    frame_is_env_next   = frame_is_env;
    sum_base            = running_sum;
    store_we            = 1'b0;
    emit                = 1'b0;
    unique case (phase_eff)
      PH_HUNT: begin
        if (c != SYNC_BYTE) begin
          byte_count_next = 4'd0;
        end else if (cnt_eff == 4'd1) begin
          parse_phase_next = PH_TYPE;
          byte_count_next  = 4'd0;
        end else begin
          sum_base        = 8'd0;
          byte_count_next = 4'd1;
        end
      end
      PH_TYPE: begin
        if (c == TYPE_LIGHT || c == TYPE_ENV) begin
          frame_is_env_next = c == TYPE_ENV;
          parse_phase_next  = PH_LEN;
        end else begin
          parse_phase_next = PH_HUNT;
          byte_count_next  = 4'd0;
        end
      end
      PH_LEN: begin
        if (c != (frame_is_env ? LEN_ENV : LEN_LIGHT)) begin
          parse_phase_next = PH_HUNT;
          byte_count_next  = 4'd0;
        end else begin
          parse_phase_next    = PH_PAY;
          expected_count_next = c[3:0] + 4'd1;
          byte_count_next     = 4'd0;
        end
      end
      PH_PAY: begin
        store_we        = {1'b0, cnt_eff} < 5'(PAYLOAD_BYTES);
        byte_count_next = cnt_inc;
        if (cnt_inc >= expected_count) begin
          parse_phase_next = PH_HUNT;
          byte_count_next  = 4'd0;
          emit             = c == running_sum;
        end
      end
      default: begin
        parse_phase_next = PH_HUNT;
      end
    endcase
  end

  // field decode from the buffered payload bytes
  always_comb begin
    res = '0;
    if (frame_is_env) begin
      res.temperature_hundredths = {payload_store[0], payload_store[1]};
      res.pressure_hundredths    = {payload_store[2], payload_store[3],
                                    payload_store[4], payload_store[5]};
      res.humidity_hundredths    = {payload_store[6], payload_store[7]};
      res.altitude_hundredths    = {payload_store[8], payload_store[9]};
    end else begin
      res.lux_hundredths = {payload_store[0], payload_store[1],
                            payload_store[2], payload_store[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (pop && store_we) begin
      payload_store[cnt_eff[IDX_W-1:0]] <= c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase    <= PH_HUNT;
      byte_count     <= '0;
      expected_count <= '0;
      frame_is_env   <= 1'b0;
      running_sum    <= '0;
    end else if (pop) begin
      parse_phase    <= parse_phase_next;
      byte_count     <= byte_count_next;
      expected_count <= expected_count_next;
      frame_is_env   <= frame_is_env_next;
      running_sum    <= sum_base + c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && emit) begin
      out_kind   <= frame_is_env;
      out_result <= res;
    end
  end

endmodule
